@@ rtl/lcsu_pkg.sv @@
// Shared constants, types and the B3/S23 cell rule for the life stencil unit.
// No dependencies; every other file imports this package.
package lcsu_pkg;

    localparam int MAX_WIDTH  = 32;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W      = 5;
    localparam int ROW_W      = 10;
    localparam int WREG_W     = 6;
    localparam int HREG_W     = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int MASK_W     = MAX_WIDTH + 1;
    localparam int EXT_W      = MAX_WIDTH + 2;
    localparam int CNT_W      = 4;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    localparam logic [WREG_W-1:0] GRID_WIDTH_RST  = 6'd32;
    localparam logic [HREG_W-1:0] GRID_HEIGHT_RST = 11'd32;

    localparam logic [CNT_W-1:0] LIFE_BORN = 4'd3;
    localparam logic [CNT_W-1:0] LIFE_KEEP = 4'd2;

    typedef logic [MAX_WIDTH-1:0] row_t;

    typedef struct packed {
        logic              run;
        logic              burst;
        logic              more;
        row_t              up;
        row_t              mid;
        row_t              down;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [COL_W-1:0]  col_end;
    } job_t;

    function automatic logic life_rule(input row_t up, input row_t mid,
                                       input row_t down, input logic [COL_W-1:0] x);
        logic [EXT_W-1:0] eu;
        logic [EXT_W-1:0] em;
        logic [EXT_W-1:0] ed;
        logic [2:0]       wu;
        logic [2:0]       wm;
        logic [2:0]       wd;
        logic [CNT_W-1:0] n;
        eu = {1'b0, up, 1'b0};
        em = {1'b0, mid, 1'b0};
        ed = {1'b0, down, 1'b0};
        wu = eu[x +: 3];
        wm = em[x +: 3];
        wd = ed[x +: 3];
        n  = CNT_W'(wu[0]) + CNT_W'(wu[1]) + CNT_W'(wu[2])
           + CNT_W'(wd[0]) + CNT_W'(wd[1]) + CNT_W'(wd[2])
           + CNT_W'(wm[0]) + CNT_W'(wm[2]);
        if (n == LIFE_BORN)
        begin
            return 1'b1;
        end
        if (n == LIFE_KEEP)
        begin
            return wm[1];
        end
        return 1'b0;
    endfunction

endpackage

@@ rtl/lcsu_front.sv @@
// Front end: size registers, window row stores, raster position and job setup.
// Depends on lcsu_pkg.
module lcsu_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [lcsu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lcsu_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           take,
    input  logic                           cell_alive,
    output lcsu_pkg::job_t                 job,
    output lcsu_pkg::row_t                 wmask
);
    import lcsu_pkg::*;

    logic [WREG_W-1:0] grid_width_reg;
    logic [HREG_W-1:0] grid_height_reg;
    row_t              row0_reg;
    row_t              row1_reg;
    row_t              row2_reg;
    row_t              row0_next;
    row_t              row1_next;
    row_t              row2_next;
    logic [COL_W-1:0]  col_count_reg;
    logic [COL_W-1:0]  col_count_next;
    logic [ROW_W-1:0]  row_count_reg;
    logic [ROW_W-1:0]  row_count_next;

    logic [WREG_W-1:0] w_eff;
    logic [HREG_W-1:0] h_eff;
    logic [COL_W-1:0]  c_lim;
    logic [ROW_W-1:0]  r_lim;
    logic [COL_W-1:0]  c;
    logic [ROW_W-1:0]  r;
    logic [MASK_W-1:0] mask_full;
    row_t              row2_new;
    logic              row_end;
    logic              frame_end;
    logic              normal;

    always_comb
    begin
        if (grid_width_reg == '0)
        begin
            w_eff = WREG_W'(1);
        end
        else if (grid_width_reg > WREG_W'(MAX_WIDTH))
        begin
            w_eff = WREG_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = grid_width_reg;
        end
        if (grid_height_reg == '0)
        begin
            h_eff = HREG_W'(1);
        end
        else if (grid_height_reg > HREG_W'(MAX_HEIGHT))
        begin
            h_eff = HREG_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = grid_height_reg;
        end
    end

    assign c_lim     = COL_W'(w_eff - WREG_W'(1));
    assign r_lim     = ROW_W'(h_eff - HREG_W'(1));
    assign c         = (col_count_reg > c_lim) ? c_lim : col_count_reg;
    assign r         = (row_count_reg > r_lim) ? r_lim : row_count_reg;
    assign mask_full = (MASK_W'(1) << w_eff) - MASK_W'(1);
    assign wmask     = mask_full[MAX_WIDTH-1:0];
    assign row_end   = (c == c_lim);
    assign frame_end = row_end && (r == r_lim);
    assign normal    = (r != '0) && ((c != '0) || row_end);

    always_comb
    begin
        row2_new    = row2_reg;
        row2_new[c] = cell_alive;
    end

    // Build the release job for the cell being transferred.
    always_comb
    begin
        job.run   = normal || frame_end;
        job.burst = 1'b0;
        job.more  = 1'b0;
        job.up    = row0_reg;
        job.mid   = row1_reg;
        job.down  = row2_new;
        job.row   = ROW_W'(r - ROW_W'(1));
        job.col   = (c != '0) ? COL_W'(c - COL_W'(1)) : c;
        job.col_end = row_end ? c : COL_W'(c - COL_W'(1));
        if (normal)
        begin
            job.more = frame_end;
        end
        else
        begin
            job.burst   = 1'b1;
            job.up      = row1_reg;
            job.mid     = row2_new;
            job.down    = '0;
            job.row     = r;
            job.col     = '0;
            job.col_end = c;
        end
    end

    // Advance the window and raster position.
    always_comb
    begin
        row0_next      = row0_reg;
        row1_next      = row1_reg;
        row2_next      = row2_reg;
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (take)
        begin
            if (frame_end)
            begin
                row0_next      = '0;
                row1_next      = '0;
                row2_next      = '0;
                col_count_next = '0;
                row_count_next = '0;
            end
            else if (row_end)
            begin
                row0_next      = row1_reg;
                row1_next      = row2_new;
                row2_next      = '0;
                col_count_next = '0;
                row_count_next = ROW_W'(r + ROW_W'(1));
            end
            else
            begin
                row2_next      = row2_new;
                col_count_next = COL_W'(c + COL_W'(1));
                row_count_next = r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
            row0_reg        <= '0;
            row1_reg        <= '0;
            row2_reg        <= '0;
            col_count_reg   <= '0;
            row_count_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata[WREG_W-1:0];
                    REG_GRID_HEIGHT: grid_height_reg <= cfg_wdata[HREG_W-1:0];
                    default:         grid_width_reg  <= grid_width_reg;
                endcase
            end
            row0_reg      <= row0_next;
            row1_reg      <= row1_next;
            row2_reg      <= row2_next;
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

endmodule

@@ rtl/lcsu_seq.sv @@
// Output sequencer: job register, rule evaluation and the result register.
// Depends on lcsu_pkg.
module lcsu_seq (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  lcsu_pkg::job_t            job,
    input  lcsu_pkg::row_t            wmask,
    output logic                      free,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [lcsu_pkg::ROW_W-1:0] out_row,
    output logic [lcsu_pkg::COL_W-1:0] out_col,
    output logic                      next_alive,
    output logic                      run_last,
    output logic                      frame_last
);
    import lcsu_pkg::*;

    logic             j_active_reg;
    logic             j_active_next;
    logic             j_burst_reg;
    logic             j_burst_next;
    logic             j_more_reg;
    logic             j_more_next;
    row_t             j_up_reg;
    row_t             j_up_next;
    row_t             j_mid_reg;
    row_t             j_mid_next;
    row_t             j_down_reg;
    row_t             j_down_next;
    logic [ROW_W-1:0] j_row_reg;
    logic [ROW_W-1:0] j_row_next;
    logic [COL_W-1:0] j_col_reg;
    logic [COL_W-1:0] j_col_next;
    logic [COL_W-1:0] j_end_reg;
    logic [COL_W-1:0] j_end_next;

    logic             out_valid_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic             next_alive_reg;
    logic             run_last_reg;
    logic             frame_last_reg;

    logic             emit;
    logic             seg_end;
    logic             j_last;
    logic             alive;

    assign emit    = j_active_reg && (!out_valid_reg || out_ready);
    assign seg_end = (j_col_reg == j_end_reg);
    assign j_last  = seg_end && !j_more_reg;
    assign free    = !j_active_reg || (emit && j_last);
    assign alive   = life_rule(j_up_reg & wmask, j_mid_reg & wmask,
                               j_down_reg & wmask, j_col_reg);

    always_comb
    begin
        j_active_next = j_active_reg;
        j_burst_next  = j_burst_reg;
        j_more_next   = j_more_reg;
        j_up_next     = j_up_reg;
        j_mid_next    = j_mid_reg;
        j_down_next   = j_down_reg;
        j_row_next    = j_row_reg;
        j_col_next    = j_col_reg;
        j_end_next    = j_end_reg;
        if (load)
        begin
            j_active_next = job.run;
            j_burst_next  = job.burst;
            j_more_next   = job.more;
            j_up_next     = job.up;
            j_mid_next    = job.mid;
            j_down_next   = job.down;
            j_row_next    = job.row;
            j_col_next    = job.col;
            j_end_next    = job.col_end;
        end
        else if (emit)
        begin
            if (!seg_end)
            begin
                j_col_next = COL_W'(j_col_reg + COL_W'(1));
            end
            else if (j_more_reg)
            begin
                // Slide the window down one row for the last-row sweep.
                j_burst_next = 1'b1;
                j_more_next  = 1'b0;
                j_up_next    = j_mid_reg;
                j_mid_next   = j_down_reg;
                j_down_next  = '0;
                j_row_next   = ROW_W'(j_row_reg + ROW_W'(1));
                j_col_next   = '0;
            end
            else
            begin
                j_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_active_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            j_active_reg <= j_active_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        j_burst_reg <= j_burst_next;
        j_more_reg  <= j_more_next;
        j_up_reg    <= j_up_next;
        j_mid_reg   <= j_mid_next;
        j_down_reg  <= j_down_next;
        j_row_reg   <= j_row_next;
        j_col_reg   <= j_col_next;
        j_end_reg   <= j_end_next;
        if (emit)
        begin
            out_row_reg    <= j_row_reg;
            out_col_reg    <= j_col_reg;
            next_alive_reg <= alive;
            run_last_reg   <= j_last;
            frame_last_reg <= j_burst_reg && seg_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign next_alive = next_alive_reg;
    assign run_last   = run_last_reg;
    assign frame_last = frame_last_reg;

endmodule

@@ rtl/life_cell_stencil_update_unit.sv @@
// Top level of the streaming B3/S23 life stencil unit.
// Depends on lcsu_pkg, lcsu_front and lcsu_seq.
//
// Usage:
//   Cells of one generation enter on the in_valid/in_ready channel in raster
//   order, one bit per transfer. Cells of the next generation leave on the
//   out_valid/out_ready channel in raster order with their row and column.
//   Board size comes from grid_width (index 0) and grid_height (index 1) on
//   the write port; write them only while the unit is idle.
// Flow:
//   A cell transferred in is loaded into the job register, and its first
//   released result reaches the outputs through the result register.
//   Throughput is one cell per cycle inside a row while out_ready is high.
//   A row end releases two results; the last cell of the board releases two
//   plus a full row of results. The output sequencer moves one result per
//   cycle while out_ready is high and frees up as it moves a job's last one.
// Reset: row stores and position clear, width and height return to 32.
// Stall: when out_ready is low the result register holds, the sequencer
//   stops, and in_ready drops once the sequencer has a job waiting.
module life_cell_stencil_update_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [lcsu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lcsu_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           cell_alive,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lcsu_pkg::ROW_W-1:0]      out_row,
    output logic [lcsu_pkg::COL_W-1:0]      out_col,
    output logic                           next_alive,
    output logic                           run_last,
    output logic                           frame_last
);
    import lcsu_pkg::*;

    job_t job;
    row_t wmask;
    logic take;
    logic seq_free;

    assign in_ready = seq_free;
    assign take     = in_valid && seq_free;

    lcsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .take       (take),
        .cell_alive (cell_alive),
        .job        (job),
        .wmask      (wmask)
    );

    lcsu_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take),
        .job        (job),
        .wmask      (wmask),
        .free       (seq_free),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .out_row    (out_row),
        .out_col    (out_col),
        .next_alive (next_alive),
        .run_last   (run_last),
        .frame_last (frame_last)
    );

endmodule

@@ rtl/lcsu_checker.sv @@
// Port-level checks for the life stencil unit, bound to the top level.
// Depends on lcsu_pkg and life_cell_stencil_update_unit.
module lcsu_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [lcsu_pkg::ROW_W-1:0] out_row,
    input logic [lcsu_pkg::COL_W-1:0] out_col,
    input logic                      next_alive,
    input logic                      run_last,
    input logic                      frame_last
);
    import lcsu_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_row)
            && $stable(out_col) && $stable(next_alive) && $stable(run_last)
            && $stable(frame_last)))
        else $error("result changed while stalled");

    a_frame_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_last) |-> run_last)
        else $error("board end without run end");

    a_burst_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !run_last) |=> out_valid)
        else $error("gap inside a released run");

    a_burst_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !run_last) |=>
            ((out_col == COL_W'($past(out_col) + COL_W'(1))
                && out_row == $past(out_row))
            || (out_col == '0 && out_row == ROW_W'($past(out_row) + ROW_W'(1)))))
        else $error("released run out of raster order");

endmodule

bind life_cell_stencil_update_unit lcsu_checker u_lcsu_checker (.*);
